@@ rtl/jvs_pkg.sv @@
// Shared types and constants for the bus packet deframer.
package jvs_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;
  localparam int unsigned AddrW = 3;

  localparam logic [ByteW-1:0] SyncReset   = 8'hE0;
  localparam logic [ByteW-1:0] EscapeReset = 8'hD0;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_BAD      = 3'd2,
    KIND_ABORT    = 3'd3,
    KIND_ZERO_LEN = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_ADDR = 3'b001,
    PH_LEN  = 3'b010,
    PH_PAY  = 3'b100
  } phase_t;

  typedef enum logic {
    REG_SYNC   = 1'b0,
    REG_ESCAPE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ByteW-1:0] sync_byte;
    logic [ByteW-1:0] escape_byte;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [ByteW-1:0] value;
    logic [ByteW-1:0] dest;
  } res_t;

endpackage

@@ rtl/jvs_cfg_regs.sv @@
// APB register file holding the sync and escape byte values.
module jvs_cfg_regs
  import jvs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [ByteW-1:0] sync_r, sync_nxt;
  logic [ByteW-1:0] esc_r, esc_nxt;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[2]);

  always_comb begin
    sync_nxt = sync_r;
    esc_nxt  = esc_r;
    if (wr_en) begin
      unique case (idx)
        REG_SYNC:   sync_nxt = pwdata[ByteW-1:0];
        REG_ESCAPE: esc_nxt  = pwdata[ByteW-1:0];
        default:    sync_nxt = sync_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SyncReset;
      esc_r  <= EscapeReset;
    end else begin
      sync_r <= sync_nxt;
      esc_r  <= esc_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SYNC:   prdata[ByteW-1:0] = sync_r;
      REG_ESCAPE: prdata[ByteW-1:0] = esc_r;
      default:    prdata = '0;
    endcase
  end

  assign cfg.sync_byte   = sync_r;
  assign cfg.escape_byte = esc_r;

endmodule

@@ rtl/jvs_deframe_core.sv @@
// Framing state and the per-byte decode step.
module jvs_deframe_core
  import jvs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             step,
  input  logic [ByteW-1:0] rx_byte,
  output res_t             res
);

  phase_t           phase_r, phase_nxt;
  logic             esc_r, esc_nxt;
  logic [ByteW-1:0] sum_r, sum_nxt;
  logic [ByteW-1:0] dest_r, dest_nxt;
  logic [ByteW-1:0] len_r, len_nxt;
  logic [ByteW-1:0] cnt_r, cnt_nxt;

  logic             is_sync, is_esc, last;
  logic [ByteW-1:0] b;

  assign is_sync = !esc_r && (rx_byte == cfg.sync_byte);
  assign is_esc  = !esc_r && (rx_byte == cfg.escape_byte);
  assign b       = esc_r ? rx_byte + ByteW'(1) : rx_byte;
  assign last    = (cnt_r == len_r - ByteW'(1));

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    sum_nxt   = sum_r;
    dest_nxt  = dest_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    res.valid = 1'b0;
    res.kind  = KIND_PAYLOAD;
    res.value = '0;
    res.dest  = dest_r;
    priority if (is_sync) begin
      phase_nxt = PH_ADDR;
      cnt_nxt   = '0;
      if (phase_r == PH_LEN || phase_r == PH_PAY) begin
        res.valid = 1'b1;
        res.kind  = KIND_ABORT;
      end
    end else if (is_esc) begin
      esc_nxt = 1'b1;
    end else begin
      esc_nxt = 1'b0;
      unique case (phase_r)
        PH_LEN: begin
          len_nxt = b;
          sum_nxt = sum_r + b;
          cnt_nxt = '0;
          if (b == '0) begin
            phase_nxt = PH_ADDR;
            res.valid = 1'b1;
            res.kind  = KIND_ZERO_LEN;
          end else begin
            phase_nxt = PH_PAY;
          end
        end
        PH_PAY: begin
          res.valid = 1'b1;
          res.value = b;
          if (last) begin
            res.kind  = (b == sum_r) ? KIND_GOOD : KIND_BAD;
            phase_nxt = PH_ADDR;
            cnt_nxt   = '0;
          end else begin
            res.kind = KIND_PAYLOAD;
            cnt_nxt  = cnt_r + ByteW'(1);
            sum_nxt  = sum_r + b;
          end
        end
        default: begin
          dest_nxt  = b;
          sum_nxt   = b;
          cnt_nxt   = '0;
          phase_nxt = PH_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ADDR;
      esc_r   <= 1'b0;
      sum_r   <= '0;
      dest_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      sum_r   <= sum_nxt;
      dest_r  <= dest_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ rtl/jvs_out_stage.sv @@
// Result register with valid/stall handshake.
module jvs_out_stage
  import jvs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  res_t             res,
  input  logic             out_stall,
  output logic             free,
  output logic             out_valid,
  output logic [KindW-1:0] out_kind,
  output logic [ByteW-1:0] out_byte_value,
  output logic [ByteW-1:0] out_packet_dest
);

  logic             vld_r, vld_nxt;
  kind_t            kind_r;
  logic [ByteW-1:0] val_r;
  logic [ByteW-1:0] dest_r;

  assign free    = !vld_r || !out_stall;
  assign vld_nxt = load ? 1'b1 : (vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res.kind;
      val_r  <= res.value;
      dest_r <= res.dest;
    end
  end

  assign out_valid       = vld_r;
  assign out_kind        = kind_r;
  assign out_byte_value  = val_r;
  assign out_packet_dest = dest_r;

endmodule

@@ rtl/jvs_packet_deframer_top.sv @@
// Top level of the bus packet deframer.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | in_rx_byte
//   out_    | output    | out_valid / out_stall | out_kind, out_byte_value, out_packet_dest
//   cfg     | APB slave | psel/penable/pready   | paddr, pwdata, prdata
//
// One item per cycle while in_stall is low: an item is held in the input register,
// the decode step updates the framing state and loads the result register.
// A result reaches the out_ ports through the input register and then the result register.
// Reset: phase awaits an address, sync 0xE0, escape 0xD0, no items held.
// in_stall rises only while the result register is full and stalled.
module jvs_packet_deframer_top
  import jvs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] in_rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KindW-1:0] out_kind,
  output logic [ByteW-1:0] out_byte_value,
  output logic [ByteW-1:0] out_packet_dest,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t             cfg;
  res_t             res;
  logic             s1_vld_r, s1_vld_nxt;
  logic [ByteW-1:0] s1_byte_r;
  logic             out_free, adv, in_acc;

  jvs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign adv        = s1_vld_r && (!res.valid || out_free);
  assign in_stall   = s1_vld_r && !adv;
  assign in_acc     = in_valid && !in_stall;
  assign s1_vld_nxt = in_acc ? 1'b1 : (s1_vld_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  jvs_deframe_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (adv),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  jvs_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (adv && res.valid),
    .res             (res),
    .out_stall       (out_stall),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_byte_value  (out_byte_value),
    .out_packet_dest (out_packet_dest)
  );

endmodule

@@ rtl/jvs_checker.sv @@
// Port-level checks for the deframer top level, bound to it.
module jvs_checker
  import jvs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [KindW-1:0] out_kind,
  input logic [ByteW-1:0] out_byte_value,
  input logic [ByteW-1:0] out_packet_dest
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side free");

  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ABORT || out_kind == KIND_ZERO_LEN)
      |-> out_byte_value == '0)
    else $error("abort or zero length carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind)
      && $stable(out_byte_value) && $stable(out_packet_dest))
    else $error("stalled result changed");

endmodule

bind jvs_packet_deframer_top jvs_checker u_jvs_checker (.*);

@@ tb/sv/jvs_packet_deframer_top_tb.sv @@
// Self-checking testbench for the bus packet deframer: directed table, random frames, APB setup.
module jvs_packet_deframer_top_tb;
  import jvs_pkg::*;

  typedef struct {
    logic [ByteW-1:0] b;
    bit               typed;
    kind_t            kind;
    logic [ByteW-1:0] value;
    logic [ByteW-1:0] dest;
  } rx_item_t;

  typedef struct {
    kind_t            kind;
    logic [ByteW-1:0] value;
    logic [ByteW-1:0] dest;
  } frame_out_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] in_rx_byte = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [KindW-1:0] out_kind;
  logic [ByteW-1:0] out_byte_value;
  logic [ByteW-1:0] out_packet_dest;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  jvs_packet_deframer_top uut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_rx_byte,
    .out_valid, .out_stall, .out_kind, .out_byte_value, .out_packet_dest,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [ByteW-1:0] cfg_sync = SyncReset;
  logic [ByteW-1:0] cfg_esc  = EscapeReset;
  phase_t           fr_phase = PH_ADDR;
  bit               esc_pending = 1'b0;
  logic [ByteW-1:0] run_sum = '0;
  logic [ByteW-1:0] pkt_dest = '0;
  logic [ByteW-1:0] frm_len = '0;
  logic [ByteW-1:0] pay_cnt = '0;

  rx_item_t   rx_bytes_q[$];
  frame_out_t pending_out[$];
  int         n_pushed = 0;
  int         n_accepted = 0;
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  logic       hold_long = 1'b0;
  event       hold_go;

  rx_item_t   on_bus;
  frame_out_t predicted;
  bit         has_res;

  // directed items, reset register values (sync E0, escape D0)
  rx_item_t dir_tab [26] = '{
    '{8'hE0, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},  // sync while idle
    '{8'h00, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},
    '{8'h01, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},
    '{8'h01, 1'b1, KIND_GOOD,     8'h01, 8'h00},
    '{8'hFF, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},  // address without sync
    '{8'h00, 1'b1, KIND_ZERO_LEN, 8'h00, 8'hFF},
    '{8'h05, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},
    '{8'h03, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},
    '{8'hFF, 1'b1, KIND_PAYLOAD,  8'hFF, 8'h05},
    '{8'hD0, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},
    '{8'hDF, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},  // escaped sync value
    '{8'hE7, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},
    '{8'h12, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},
    '{8'h04, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},
    '{8'h00, 1'b1, KIND_PAYLOAD,  8'h00, 8'h12},
    '{8'hE0, 1'b1, KIND_ABORT,    8'h00, 8'h12},
    '{8'h34, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},
    '{8'h02, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},
    '{8'hD0, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},
    '{8'hCF, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},  // escaped escape value
    '{8'h00, 1'b1, KIND_BAD,      8'h00, 8'h34},
    '{8'h77, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},
    '{8'hE0, 1'b1, KIND_ABORT,    8'h00, 8'h77},  // sync right after address
    '{8'hD0, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},
    '{8'hFF, 1'b0, KIND_PAYLOAD,  8'h00, 8'h00},  // escape wraps to 00
    '{8'h00, 1'b1, KIND_ZERO_LEN, 8'h00, 8'h00}
  };

  function automatic bit deframe_byte(input logic [ByteW-1:0] raw, output frame_out_t r);
    logic [ByteW-1:0] b;
    bit               was_inside;
    b = raw;
    r = '{KIND_PAYLOAD, 8'h00, 8'h00};
    if (!esc_pending && b == cfg_sync) begin
      was_inside = (fr_phase == PH_LEN || fr_phase == PH_PAY);
      fr_phase = PH_ADDR;
      pay_cnt = '0;
      if (was_inside) begin
        r = '{KIND_ABORT, 8'h00, pkt_dest};
        return 1'b1;
      end
      return 1'b0;
    end
    if (!esc_pending && b == cfg_esc) begin
      esc_pending = 1'b1;
      return 1'b0;
    end
    if (esc_pending) begin
      b = b + 8'd1;
      esc_pending = 1'b0;
    end
    case (fr_phase)
      PH_LEN: begin
        frm_len = b;
        run_sum = run_sum + b;
        pay_cnt = '0;
        if (b == 8'd0) begin
          fr_phase = PH_ADDR;
          r = '{KIND_ZERO_LEN, 8'h00, pkt_dest};
          return 1'b1;
        end
        fr_phase = PH_PAY;
        return 1'b0;
      end
      PH_PAY: begin
        if (pay_cnt == frm_len - 8'd1) begin
          r = '{(b == run_sum) ? KIND_GOOD : KIND_BAD, b, pkt_dest};
          fr_phase = PH_ADDR;
          pay_cnt = '0;
          return 1'b1;
        end
        pay_cnt = pay_cnt + 8'd1;
        run_sum = run_sum + b;
        r = '{KIND_PAYLOAD, b, pkt_dest};
        return 1'b1;
      end
      default: begin
        pkt_dest = b;
        run_sum = b;
        pay_cnt = '0;
        fr_phase = PH_LEN;
        return 1'b0;
      end
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        has_res = deframe_byte(on_bus.b, predicted);
        if (on_bus.typed) begin
          pending_out.push_back('{on_bus.kind, on_bus.value, on_bus.dest});
        end else if (has_res) begin
          pending_out.push_back(predicted);
        end
        n_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = rx_bytes_q.pop_front();
          in_valid <= 1'b1;
          in_rx_byte <= on_bus.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        mismatches++;
        if (mismatches < 40)
          $display("%0t: unexpected item kind %0d value %02h dest %02h", $time,
                   out_kind, out_byte_value, out_packet_dest);
      end else begin
        predicted = pending_out.pop_front();
        if (out_kind !== predicted.kind || out_byte_value !== predicted.value ||
            out_packet_dest !== predicted.dest) begin
          mismatches++;
          if (mismatches < 40)
            $display("%0t: expected kind %0d value %02h dest %02h, got kind %0d value %02h dest %02h",
                     $time, predicted.kind, predicted.value, predicted.dest,
                     out_kind, out_byte_value, out_packet_dest);
        end
      end
    end
    out_stall <= rst_n && (hold_long || $urandom_range(99) < stall_pct);
  end

  // long receiver hold-off
  always begin
    @(hold_go);
    hold_long <= 1'b1;
    repeat (400) @(posedge clk);
    hold_long <= 1'b0;
  end

  function automatic void put_raw(input logic [ByteW-1:0] b);
    rx_bytes_q.push_back('{b, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00});
    n_pushed++;
  endfunction

  // with sync equal to escape a byte of that value cannot be sent as data
  function automatic logic [ByteW-1:0] legal(input logic [ByteW-1:0] v);
    if (cfg_sync == cfg_esc && v == cfg_sync) return v ^ 8'h01;
    return v;
  endfunction

  function automatic void put_data(input logic [ByteW-1:0] v);
    if (cfg_sync != cfg_esc && (v == cfg_sync || v == cfg_esc || $urandom_range(19) == 0)) begin
      put_raw(cfg_esc);
      put_raw(v - 8'd1);
    end else begin
      put_raw(v);
    end
  endfunction

  task automatic gen_unit();
    int               r;
    int               len;
    int               n_pay;
    logic [ByteW-1:0] addr;
    logic [ByteW-1:0] v;
    logic [ByteW-1:0] sum;
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 4)) put_raw(8'($urandom_range(255)));
      return;
    end
    if (r >= 12) put_raw(cfg_sync);
    addr = legal(8'($urandom_range(255)));
    r = $urandom_range(99);
    if (r == 0) len = 255;
    else if (r < 6) len = 0;
    else if (r < 80) len = $urandom_range(1, 6);
    else len = $urandom_range(7, 40);
    len = legal(8'(len));
    put_data(addr);
    put_data(8'(len));
    sum = addr + 8'(len);
    if (len == 0) return;
    n_pay = len - 1;
    if ($urandom_range(9) == 0) n_pay = $urandom_range(0, len - 1);  // broken frame
    for (int i = 0; i < n_pay; i++) begin
      case ($urandom_range(7))
        0: v = cfg_sync;
        1: v = cfg_esc;
        default: v = 8'($urandom_range(255));
      endcase
      v = legal(v);
      sum = sum + v;
      put_data(v);
    end
    if (n_pay != len - 1) return;
    if ($urandom_range(9) == 0) sum = sum ^ 8'($urandom_range(1, 255));
    put_data(legal(sum));
  endtask

  task automatic drain();
    while (n_accepted != n_pushed || pending_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [ByteW-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SYNC) cfg_sync = val;
    else cfg_esc = val;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, val}) begin
      mismatches++;
      $display("%0t: register %0d read expected %08h, got %08h", $time, idx, {24'd0, val},
               prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [ByteW-1:0] sync_set [6];
    logic [ByteW-1:0] esc_set [6];
    int               target;
    sync_set = '{8'hE0, 8'h00, 8'hFF, 8'h55, 8'h00, 8'hE0};
    esc_set  = '{8'hD0, 8'hFF, 8'h00, 8'h55, 8'h00, 8'hD0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      rx_bytes_q.push_back(dir_tab[i]);
      n_pushed++;
    end
    drain();

    for (int k = 0; k < 6; k++) begin
      if (k == 4) begin
        sync_set[k] = 8'($urandom_range(255));
        esc_set[k]  = 8'($urandom_range(255));
      end
      write_reg(REG_SYNC, sync_set[k]);
      write_reg(REG_ESCAPE, esc_set[k]);
      case (k % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      target = n_pushed + 250;
      while (n_pushed < target) gen_unit();
      drain();
    end

    // receiver holds off while the sender keeps offering payload
    send_idle_pct = 0;
    stall_pct = 0;
    put_raw(cfg_sync);
    put_data(legal(8'h3C));
    put_data(legal(8'd40));
    repeat (38) put_data(legal(8'($urandom_range(255))));
    ->hold_go;
    drain();

    if (mismatches == 0)
      $display("jvs_packet_deframer_top_tb: clean");
    else
      $display("jvs_packet_deframer_top_tb: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("jvs_packet_deframer_top_tb: errors");
    $finish;
  end

endmodule
